// File: sv/xor_frame_receiver_assert.svh
// Assertion macros used by the receiver top level.
`ifndef XOR_FRAME_RECEIVER_ASSERT_SVH
`define XOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define XFR_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define XFR_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/xfr_pkg.sv
package xfr_pkg;

    // Frame store geometry
    localparam int FRAME_AW    = 8;
    localparam int FRAME_DEPTH = 256;

    // Largest usable length limit, so a frame always fits the frame store
    localparam logic [7:0] LIMIT_MAX = 8'd253;

    // Configuration register indexes and reset values
    localparam logic [0:0] CFG_END_MARKER   = 1'b0;
    localparam logic [0:0] CFG_LENGTH_LIMIT = 1'b1;
    localparam logic [7:0] END_MARKER_RST   = 8'd10;
    localparam logic [7:0] LENGTH_LIMIT_RST = 8'd150;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_BYTE_END = 2'd1,
        KIND_READ     = 2'd2
    } t_kind;

    // Queue entry: class plus the one byte that class needs
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_qitem;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_CHK,
        ST_LIM,
        ST_XOR,
        ST_XOR_END,
        ST_COPY,
        ST_COPY_END,
        ST_EMIT
    } t_state;

endpackage

// File: sv/xor_frame_receiver.sv
// Sequence: a read beat or a received byte without a frame check passes ST_IDLE and ST_EMIT;
//   a frame check runs ST_LEN, ST_CHK, ST_LIM, then ST_XOR and ST_XOR_END if the length is
//   under the limit, then ST_COPY and ST_COPY_END on a checksum match, before ST_EMIT.
// The back end handles one beat at a time; the check walks the ring store through its single
//   read port, once for the checksum and once for the copy. A 2-entry queue buffers input beats.
// Reset: synchronous, active low. Afterwards a clearing pass over every ring address zeroes
//   both stores with s_axis_tready low; configuration writes are taken throughout.
module xor_frame_receiver #(
    parameter int RING_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], read_offset [15:8]
    input  logic        s_axis_tuser,   // cmd
    input  logic        s_axis_tlast,   // batch_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // frame_len [7:0], read_data [15:8]
    output logic [1:0]  m_axis_tuser    // frame_done [0], overflow_reset [1]
);
    import xfr_pkg::*;

`include "xor_frame_receiver_assert.svh"

    logic [7:0] r_end_marker;
    logic [7:0] r_length_limit;
    logic       w_q_valid;
    t_qitem     w_q_item;
    logic       w_q_pop;
    logic       w_clearing;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker   <= END_MARKER_RST;
            r_length_limit <= LENGTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    xfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (w_clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    xfr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_end_marker   (r_end_marker),
        .i_length_limit (r_length_limit),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_clearing     (w_clearing),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    // No beat is taken while the stores are being cleared
    `XFR_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, w_clearing, !s_axis_tready,
                    "beat taken during clearing pass")

    // A completed frame is never an overflow byte or a read result
    `XFR_ASSERT_IMP(a_done_is_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
                    !m_axis_tuser[1] && (m_axis_tdata[15:8] == 8'd0),
                    "frame_done with overflow or read data")

    // A completed frame always has a length below the usable limit
    `XFR_ASSERT_IMP(a_done_len_in_range, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tdata[7:0] < LIMIT_MAX, "frame_done with length out of range")

    // The queue is never popped while the stores are being cleared
    `XFR_ASSERT_NXT(a_clear_then_no_pop, i_clk, i_rst_n, w_clearing && $past(w_clearing),
                    !w_q_pop || !w_clearing, "queue popped during clearing pass")

endmodule

// File: sv/xfr_front.sv
module xfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [15:0]    s_axis_tdata,   // rx_byte [7:0], read_offset [15:8]
    input  logic           s_axis_tuser,   // cmd
    input  logic           s_axis_tlast,   // batch_end
    output logic           o_q_valid,
    output xfr_pkg::t_qitem o_q_item,
    input  logic           i_q_pop
);
    import xfr_pkg::*;

    t_qitem     r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    t_qitem     w_item;
    logic       w_push;

    // Classify the incoming beat
    always_comb begin
        if (s_axis_tuser) begin
            w_item.kind = KIND_READ;
            w_item.data = s_axis_tdata[15:8];
        end else begin
            w_item.kind = s_axis_tlast ? KIND_BYTE_END : KIND_BYTE;
            w_item.data = s_axis_tdata[7:0];
        end
    end

    assign s_axis_tready = (r_count != 2'd2) && !i_hold;
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_item      = r_q[r_rd];

    // Hold entries until the back end pops them
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

// File: sv/xfr_back.sv
module xfr_back #(
    parameter int RING_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_end_marker,
    input  logic [7:0]      i_length_limit,
    input  logic            i_q_valid,
    input  xfr_pkg::t_qitem i_q_item,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,  // frame_len [7:0], read_data [15:8]
    output logic [1:0]      m_axis_tuser   // frame_done [0], overflow_reset [1]
);
    import xfr_pkg::*;

    localparam int             AW          = $clog2(RING_DEPTH);
    localparam logic [AW:0]    RING_DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0]  RING_LAST   = AW'(RING_DEPTH - 1);

    // Reduce a sum below twice the depth to a ring address
    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] v);
        logic [AW:0] d;
        d = (v >= RING_DEPTH_W) ? (v - RING_DEPTH_W) : v;
        return d[AW-1:0];
    endfunction

    // Memories
    logic [7:0] ring_mem  [RING_DEPTH];
    logic [7:0] frame_mem [FRAME_DEPTH];
    logic [7:0] ring_q;
    logic [7:0] frame_q;

    logic                ring_we;
    logic [AW-1:0]       ring_waddr;
    logic [7:0]          ring_wdata;
    logic [AW-1:0]       ring_raddr;
    logic                frame_we;
    logic [FRAME_AW-1:0] frame_waddr;
    logic [7:0]          frame_wdata;
    logic                frame_re;
    logic [FRAME_AW-1:0] frame_raddr;

    // Sequencer state
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW:0]   r_fill, n_fill;
    logic [7:0]    r_cap, n_cap;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_chk, n_chk;
    logic [7:0]    r_acc, n_acc;
    logic [AW-1:0] r_base, n_base;
    logic [7:0]    r_cnt, n_cnt;
    logic [7:0]    r_di, n_di;
    logic          r_dv, n_dv;
    logic          r_done, n_done;
    logic          r_ovf, n_ovf;
    logic          r_is_read, n_is_read;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_data, n_out_data;
    logic [1:0]    r_out_user, n_out_user;

    logic [7:0]    w_limit;
    logic [AW:0]   w_fill_inc;
    logic          w_ovf;
    logic [7:0]    w_acc_fin;

    assign w_limit    = (i_length_limit > LIMIT_MAX) ? LIMIT_MAX : i_length_limit;
    assign w_fill_inc = r_fill + 1'b1;
    assign w_ovf      = (w_fill_inc == RING_DEPTH_W);
    assign w_acc_fin  = r_acc ^ ring_q;

    // Ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q <= ring_mem[ring_raddr];
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            frame_q <= frame_mem[frame_raddr];
        end
    end

    // Next state, memory controls and result
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_cap       = r_cap;
        n_len       = r_len;
        n_chk       = r_chk;
        n_acc       = r_acc;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_di        = r_di;
        n_dv        = r_dv;
        n_done      = r_done;
        n_ovf       = r_ovf;
        n_is_read   = r_is_read;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        o_q_pop     = 1'b0;
        ring_we     = 1'b0;
        ring_waddr  = r_wp;
        ring_wdata  = i_q_item.data;
        ring_raddr  = f_wrap({1'b0, r_base} + (AW+1)'(r_cnt));
        frame_we    = 1'b0;
        frame_waddr = r_di;
        frame_wdata = ring_q;
        frame_re    = 1'b0;
        frame_raddr = i_q_item.data;

        unique case (r_state)
            // Zero both stores after reset
            ST_CLEAR: begin
                ring_we     = 1'b1;
                ring_waddr  = r_clr;
                ring_wdata  = 8'd0;
                frame_we    = ((r_clr >> FRAME_AW) == '0);
                frame_waddr = r_clr[FRAME_AW-1:0];
                frame_wdata = 8'd0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == RING_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            // Take the next queued item
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_done  = 1'b0;
                    n_state = ST_EMIT;
                    unique case (i_q_item.kind)
                        KIND_READ: begin
                            frame_re  = 1'b1;
                            n_is_read = 1'b1;
                            n_ovf     = 1'b0;
                        end
                        KIND_BYTE, KIND_BYTE_END: begin
                            ring_we   = 1'b1;
                            n_is_read = 1'b0;
                            n_ovf     = w_ovf;
                            if (w_ovf) begin
                                n_fill = '0;
                                n_wp   = '0;
                            end else begin
                                n_fill = w_fill_inc;
                                n_wp   = (r_wp == RING_LAST) ? '0 : r_wp + 1'b1;
                            end
                            if (i_q_item.kind == KIND_BYTE_END && !w_ovf &&
                                i_q_item.data == i_end_marker) begin
                                n_state = ST_LEN;
                            end
                        end
                        default: begin
                            n_is_read = 1'b0;
                            n_ovf     = 1'b0;
                        end
                    endcase
                end
            end
            // Fetch the length byte
            ST_LEN: begin
                ring_raddr = f_wrap({1'b0, r_wp} + RING_DEPTH_W - (AW+1)'(3));
                n_state    = ST_CHK;
            end
            // Latch length, fetch the checksum byte
            ST_CHK: begin
                ring_raddr = f_wrap({1'b0, r_wp} + RING_DEPTH_W - (AW+1)'(2));
                n_len      = ring_q;
                n_state    = ST_LIM;
            end
            // Latch checksum, test the length limit
            ST_LIM: begin
                n_chk  = ring_q;
                n_base = f_wrap({1'b0, r_wp} + RING_DEPTH_W - (AW+1)'(3)
                                - (AW+1)'(r_len));
                n_cnt  = 8'd0;
                n_dv   = 1'b0;
                n_acc  = 8'd0;
                n_state = (r_len >= w_limit) ? ST_EMIT : ST_XOR;
            end
            // Walk payload and length byte, fold into the checksum
            ST_XOR: begin
                n_dv = 1'b1;
                if (r_dv) begin
                    n_acc = w_acc_fin;
                end
                if (r_cnt == r_len) begin
                    n_state = ST_XOR_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // Compare the folded value with the checksum byte
            ST_XOR_END: begin
                n_cnt = 8'd0;
                n_dv  = 1'b0;
                n_state = (w_acc_fin == r_chk) ? ST_COPY : ST_EMIT;
            end
            // Copy payload, length, checksum and marker to the frame store
            ST_COPY: begin
                frame_we = r_dv;
                n_dv     = 1'b1;
                n_di     = r_cnt;
                if (r_cnt == r_len + 8'd2) begin
                    n_state = ST_COPY_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // Write the last byte and commit the frame
            ST_COPY_END: begin
                frame_we = 1'b1;
                n_cap    = r_len;
                n_fill   = '0;
                n_done   = 1'b1;
                n_state  = ST_EMIT;
            end
            // Load the output register once it is free
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {(r_is_read ? frame_q : 8'd0), r_cap};
                    n_out_user  = {r_ovf, r_done};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cap       <= 8'd0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_cap       <= n_cap;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_chk      <= n_chk;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_cnt      <= n_cnt;
        r_di       <= n_di;
        r_done     <= n_done;
        r_ovf      <= n_ovf;
        r_is_read  <= n_is_read;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_clearing    = (r_state == ST_CLEAR);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// File: tb/xor_frame_receiver_checker.sv
module xor_frame_receiver_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], read_offset [15:8]
    input  logic        s_axis_tuser,   // cmd
    input  logic        s_axis_tlast,   // batch_end
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // frame_len [7:0], read_data [15:8]
    input  logic [1:0]  m_axis_tuser,   // frame_done [0], overflow_reset [1]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import xfr_pkg::*;

    localparam int RING_SIZE = 256;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       done;
        logic [7:0] len;
        logic [7:0] rdata;
        logic       ovf;
    } t_rx_result;

    // Shadow copy of the receiver state
    logic [7:0] ring_mem [RING_SIZE];
    logic [7:0] frame_mem [FRAME_DEPTH];
    logic [7:0] wr_ptr;
    logic [8:0] fill_cnt;
    logic [7:0] cap_len;
    logic [7:0] marker_q;
    logic [7:0] limit_q;

    t_rx_result expected_q [$];
    int         fail_cnt = 0;

    // Look for a terminated frame behind the write pointer and capture it
    function automatic logic capture_frame();
        logic [7:0] len;
        logic [7:0] lim;
        logic [7:0] acc;
        logic [7:0] base;
        logic [7:0] idx;
        int         i;
        acc = '0;
        idx = wr_ptr - 8'd1;
        if (fill_cnt == '0 || ring_mem[idx] != marker_q) return 1'b0;
        idx = wr_ptr - 8'd3;
        len = ring_mem[idx];
        lim = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
        if (len >= lim) return 1'b0;
        // oldest payload byte; payload and length byte fold into the checksum
        base = wr_ptr - 8'd3 - len;
        for (i = 0; i <= len; i++) begin
            idx = base + i[7:0];
            acc ^= ring_mem[idx];
        end
        idx = wr_ptr - 8'd2;
        if (acc != ring_mem[idx]) return 1'b0;
        for (i = 0; i < len + 3; i++) begin
            idx = base + i[7:0];
            frame_mem[i] = ring_mem[idx];
        end
        cap_len  = len;
        fill_cnt = '0;
        return 1'b1;
    endfunction

    // Advance the shadow state by one input beat and return its result
    function automatic t_rx_result predict_beat(logic is_read, logic [7:0] rx,
                                                logic last, logic [7:0] offs);
        t_rx_result r;
        r = '0;
        if (is_read) begin
            r.rdata = frame_mem[offs];
        end else begin
            ring_mem[wr_ptr] = rx;
            wr_ptr   = wr_ptr + 8'd1;
            fill_cnt = fill_cnt + 9'd1;
            if (fill_cnt >= RING_SIZE) begin
                fill_cnt = '0;
                wr_ptr   = '0;
                r.ovf    = 1'b1;
            end
            if (last && capture_frame()) r.done = 1'b1;
        end
        r.len = cap_len;
        return r;
    endfunction

    task automatic report_mismatch(input string why, input t_rx_result want,
                                   input t_rx_result got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t ns: %s: expected done=%0d len=%0d data=%0d ovf=%0d,",
                     $time, why, want.done, want.len, want.rdata, want.ovf,
                     " got done=%0d len=%0d data=%0d ovf=%0d",
                     got.done, got.len, got.rdata, got.ovf);
    endtask

    // Track config writes, check result beats, predict input beats
    always @(posedge i_clk) begin
        t_rx_result got;
        t_rx_result want;
        int         k;
        if (!i_rst_n) begin
            for (k = 0; k < RING_SIZE; k++) ring_mem[k] = '0;
            for (k = 0; k < FRAME_DEPTH; k++) frame_mem[k] = '0;
            wr_ptr   = '0;
            fill_cnt = '0;
            cap_len  = '0;
            marker_q = END_MARKER_RST;
            limit_q  = LENGTH_LIMIT_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_END_MARKER:   marker_q = i_cfg_data;
                    CFG_LENGTH_LIMIT: limit_q  = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a result never belongs to a beat of this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.done  = m_axis_tuser[0];
                got.ovf   = m_axis_tuser[1];
                got.len   = m_axis_tdata[7:0];
                got.rdata = m_axis_tdata[15:8];
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) report_mismatch("result mismatch", want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_beat(s_axis_tuser, s_axis_tdata[7:0],
                                                  s_axis_tlast, s_axis_tdata[15:8]));
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: tb/xor_frame_receiver_test.sv
module xor_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xfr_pkg::*;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam int   NUM_PHASES = 6;
    localparam int   PHASE_BEATS = 210;
    localparam int   SHORT_LEN_MAX = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = CFG_END_MARKER;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = CMD_BYTE;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending;

    // Settings per phase; the limit table covers zero and values above the clamp
    logic [7:0] phase_marker [NUM_PHASES] = '{8'd10, 8'd0, 8'd255, 8'h7E, 8'hA5, 8'd10};
    logic [7:0] phase_limit  [NUM_PHASES] = '{8'd150, 8'd253, 8'd255, 8'd1, 8'd0, 8'd20};
    int         send_idle    [4] = '{0, 70, 0, 28};
    int         recv_stall   [4] = '{0, 0, 70, 28};

    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       mix_reads = 1'b0;
    logic [7:0] cur_marker = END_MARKER_RST;
    logic [7:0] cur_limit = LENGTH_LIMIT_RST;
    int         beat_count = 0;

    xor_frame_receiver #(
        .RING_DEPTH(256)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    xor_frame_receiver_checker u_frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Present one input beat, with random idle cycles ahead of it, and hold until taken
    task automatic drive_beat(input logic cmd, input logic [7:0] rx, input logic last,
                              input logic [7:0] offs);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {offs, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        beat_count++;
    endtask

    task automatic send_read(input logic [7:0] offs);
        drive_beat(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), offs);
    endtask

    // Received byte; reads may slip in ahead of it since they leave the ring alone
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (mix_reads && $urandom_range(9) == 0)
            send_read(8'($urandom_range(SHORT_LEN_MAX + 3)));
        drive_beat(CMD_BYTE, b, last, 8'($urandom_range(255)));
    endtask

    // Payload, length byte, checksum and end marker
    task automatic send_frame(input int len, input logic bad_sum, input logic last);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        sum = '0;
        for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            sum ^= b;
            send_byte(b, $urandom_range(7) == 0);
        end
        sum ^= len[7:0];
        send_byte(len[7:0], 1'b0);
        if (bad_sum) sum ^= 8'h01 << $urandom_range(7);
        send_byte(sum, 1'b0);
        send_byte(cur_marker, last);
    endtask

    // Drop valid and hold until every expected result beat has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int ph;
        int n;
        int pick;
        int eff_lim;
        int short_max;
        int len;
        int phase_end;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset settings
        send_read(8'd0);
        send_read(8'd255);
        // lone marker: check runs on a stale all-zero ring and takes an empty frame
        send_byte(8'd10, 1'b1);
        // good frame with extreme payload bytes
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'd10, 1'b1);
        send_read(8'd0);
        send_read(8'd4);
        // wrong checksum
        send_byte(8'h55, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'd10, 1'b1);
        // length equal to the limit
        send_byte(8'd150, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'd10, 1'b1);
        // marker without batch end, then a read that carries batch end
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'd10, 1'b0);
        drive_beat(CMD_READ, 8'd10, 1'b1, 8'd2);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // Write both registers while idle
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_END_MARKER;
            i_cfg_data <= phase_marker[ph];
            @(posedge i_clk);
            i_cfg_idx  <= CFG_LENGTH_LIMIT;
            i_cfg_data <= phase_limit[ph];
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            cur_marker = phase_marker[ph];
            cur_limit  = phase_limit[ph];
            idle_pct   = send_idle[ph % 4];
            stall_pct  = recv_stall[ph % 4];
            mix_reads  = 1'b1;

            eff_lim   = (cur_limit > LIMIT_MAX) ? LIMIT_MAX : cur_limit;
            short_max = (eff_lim == 0) ? SHORT_LEN_MAX :
                        ((eff_lim - 1 < SHORT_LEN_MAX) ? eff_lim - 1 : SHORT_LEN_MAX);
            phase_end = beat_count + PHASE_BEATS;

            // Ring wrap: empty frame clears the count, then 256 more bytes overflow it
            if (ph == 0 || ph == 5) begin
                send_frame(0, 1'b0, 1'b1);
                repeat (255) send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(cur_marker, 1'b1);
            end
            // Longest frame the clamped limit lets through
            if (ph == 2) begin
                send_frame(eff_lim - 1, 1'b0, 1'b1);
                for (n = 0; n < 4; n++) send_read(8'(eff_lim - 1 + n));
            end

            while (beat_count < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    len = (eff_lim > 1 && $urandom_range(24) == 0) ?
                          $urandom_range(eff_lim - 1) : $urandom_range(short_max);
                    send_frame(len, 1'b0, 1'b1);
                end else if (pick < 62) begin
                    send_frame($urandom_range(short_max), 1'b1, 1'b1);
                end else if (pick < 70) begin
                    // length byte at or above the limit
                    repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0);
                    send_byte(8'($urandom_range(255, eff_lim)), 1'b0);
                    send_byte(8'($urandom_range(255)), 1'b0);
                    send_byte(cur_marker, 1'b1);
                end else if (pick < 76) begin
                    send_frame($urandom_range(short_max), 1'b0, 1'b0);
                end else if (pick < 90) begin
                    repeat ($urandom_range(4, 1))
                        send_read(8'($urandom_range(1) ? $urandom_range(short_max + 3)
                                                       : $urandom_range(255)));
                end else begin
                    repeat ($urandom_range(6, 1))
                        send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                end
            end
            wait_drained();
        end

        // Settle for the longest frame check, then give the verdict
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS xor_frame_receiver");
        end else begin
            $display("FAIL xor_frame_receiver");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("FAIL xor_frame_receiver");
        $finish;
    end

endmodule
